// ----- hdl/lfpd_pkg.sv -----
// Shared types and constants for the line-follow PD steering block.
// Used by lfpd_ctrl, lfpd_dp and line_follow_pd_steering_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lfpd_pkg;

	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_START = 2'd1;
	localparam logic [OP_W-1:0] OP_RESET = 2'd2;

	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FOLLOW = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_STOP   = 3'd4;

	localparam logic [1:0] TURN_NONE  = 2'd0;
	localparam logic [1:0] TURN_POS90 = 2'd1;
	localparam logic [1:0] TURN_NEG90 = 2'd2;

	localparam logic [1:0] ROUTE_LEFT  = 2'd1;
	localparam logic [1:0] ROUTE_RIGHT = 2'd2;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEER_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_MS     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_CMDS  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_LEN   = 3'd7;

	localparam int DIV_STEPS = 16;
	localparam int CNT_W     = 4;
	localparam int NUM_W     = 58;

	localparam logic [20:0] USEC_PER_SEC = 21'd1000000;
	localparam logic [15:0] RECIP_FIVE   = 16'd52429;

	typedef struct packed {
		logic load;
		logic eval;
		logic fmul;
		logic fadd;
		logic mul1;
		logic mul2;
		logic sum;
		logic sat;
		logic div;
		logic fin;
		logic out_load;
	} lfpd_cmd_t;

	typedef struct packed {
		logic pd_go;
	} lfpd_sts_t;

endpackage
`default_nettype wire

// ----- hdl/lfpd_ctrl.sv -----
// Controller state machine: sequences evaluation, filter, PD products and the divider.
// Depends on lfpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfpd_ctrl
	import lfpd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	input  wire lfpd_sts_t sts,
	output lfpd_cmd_t      cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EVAL = 4'd1;
	localparam logic [3:0] S_FMUL = 4'd2;
	localparam logic [3:0] S_FADD = 4'd3;
	localparam logic [3:0] S_MUL1 = 4'd4;
	localparam logic [3:0] S_MUL2 = 4'd5;
	localparam logic [3:0] S_SUM  = 4'd6;
	localparam logic [3:0] S_SAT  = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             m_tvalid_q;
	logic             out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d = sts.pd_go ? S_FMUL : S_DONE;
			end
			S_FMUL: begin
				cmd.fmul = 1'b1;
				state_d = S_FADD;
			end
			S_FADD: begin
				cmd.fadd = 1'b1;
				state_d = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_SAT;
			end
			S_SAT: begin
				cmd.sat = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.sat) begin
				cnt_q <= '0;
			end else if (cmd.div) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/lfpd_dp.sv -----
// Datapath: configuration registers, follower state, filter, PD products,
// restoring divider and the result register. Depends on lfpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfpd_dp
	import lfpd_pkg::*;
#(
	parameter int ROUTE_MAX   = 16,
	parameter int DEBOUNCE_MS = 200,
	parameter int LOCKOUT_MS  = 500
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic [71:0]          in_data,
	input  wire logic [OP_W-1:0]      in_op,
	input  wire lfpd_cmd_t            cmd,
	output lfpd_sts_t                 sts,
	output logic [31:0]               out_data
);

	logic [15:0] kp_q, kd_q, alpha_q, hold_q, stopms_q;
	logic [14:0] limit_q;
	logic [31:0] route_q;
	logic [4:0]  rlen_q;

	logic [MODE_W-1:0] mode_q;
	logic signed [15:0] filt_q, prev_q, latest_q, steer_q;
	logic ready_q, ever_q, lost_q, recov_q, held_q;
	logic [31:0] last_seen_q, lockout_q, last_cross_q;
	logic [4:0]  rp_q;
	logic en_q, stopreq_q, move_q;
	logic [1:0] turn_q;

	logic [OP_W-1:0] op_q;
	logic [31:0] now_q;
	logic [15:0] dt_q;
	logic on_q, cross_q, tdone_q;
	logic signed [15:0] pos_q;

	logic signed [33:0] fp_s1;
	logic signed [32:0] pa_s2;
	logic signed [33:0] pb_s2;
	logic signed [49:0] pa_s3;
	logic signed [55:0] pb_s3;
	logic [NUM_W-1:0] n_q;
	logic [NUM_W-1:0] dv_q;
	logic neg_q, sat_q;
	logic [15:0] q_q;

	logic [31:0] lost_ms;
	logic is_tick, follow_tick, halt, recov, do_begin, do_clear;
	logic signed [15:0] err;
	logic [16:0] rec_x;
	logic [32:0] rec_p;
	logic [15:0] rec_mag;
	logic signed [16:0] fdiff;
	logic signed [17:0] fcorr;
	logic signed [56:0] num;
	logic [NUM_W-1:0] nmag;
	logic [NUM_W-1:0] sat_lim;
	logic [15:0] qmag;
	logic signed [15:0] s_val;
	logic [1:0] entry;
	logic hit;
	logic [5:0] len_in;

	assign is_tick = (op_q == OP_TICK) && (dt_q != 16'd0);
	assign follow_tick = is_tick && (mode_q == MODE_FOLLOW);
	assign lost_ms = (!on_q && ever_q) ? (now_q - last_seen_q) : 32'd0;
	assign halt = (!on_q && !ever_q) || (lost_ms > {16'd0, stopms_q});
	assign recov = !halt && (lost_ms > {16'd0, hold_q});
	assign sts.pd_go = follow_tick && !halt && !recov;
	assign do_begin = (op_q == OP_START) ||
		(is_tick && (mode_q == MODE_LEFT || mode_q == MODE_RIGHT) && tdone_q);
	assign do_clear = (op_q == OP_RESET) || do_begin || (follow_tick && halt);

	assign err = (pos_q == -16'sd32768) ? 16'sd32767 : -pos_q;
	assign rec_x = 17'(3 * {2'd0, limit_q}) + 17'd2;
	assign rec_p = {16'd0, rec_x} * {17'd0, RECIP_FIVE};
	assign rec_mag = {1'b0, rec_p[32:18]};

	assign fdiff = 17'(latest_q) - 17'(filt_q);
	assign fcorr = 18'((fp_s1 + 34'sd32768) >>> 16);

	assign num = 57'(pa_s3) + 57'(pb_s3);
	assign nmag = NUM_W'(num < 0 ? -num : num) + NUM_W'({dt_q, 11'd0});
	assign sat_lim = NUM_W'({dt_q, 28'd0});

	assign qmag = (sat_q || q_q > {1'b0, limit_q}) ? {1'b0, limit_q} : q_q;
	assign s_val = neg_q ? -$signed(qmag) : $signed(qmag);
	assign entry = (rp_q < 5'd16) ? route_q[{rp_q[3:0], 1'b0} +: 2] : 2'd0;
	assign hit = cross_q && !held_q && ((now_q - last_cross_q) > 32'(DEBOUNCE_MS));
	assign len_in = {1'b0, cfg_data[4:0]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			now_q <= in_data[31:0];
			dt_q <= in_data[47:32];
			on_q <= in_data[48];
			pos_q <= in_data[64:49];
			cross_q <= in_data[65];
			tdone_q <= in_data[66];
		end
		if (cmd.fmul) begin
			fp_s1 <= 34'($signed({1'b0, alpha_q}) * fdiff);
		end
		if (cmd.mul1) begin
			pa_s2 <= 33'($signed({1'b0, kp_q}) * filt_q);
			pb_s2 <= 34'($signed({1'b0, kd_q}) * (17'(filt_q) - 17'(prev_q)));
		end
		if (cmd.mul2) begin
			pa_s3 <= 50'(pa_s2 * $signed({1'b0, dt_q}));
			pb_s3 <= 56'(pb_s2 * $signed({1'b0, USEC_PER_SEC}));
		end
		if (cmd.sum) begin
			n_q <= nmag;
			neg_q <= (num < 0);
			dv_q <= NUM_W'({dt_q, 27'd0});
		end
		if (cmd.sat) begin
			sat_q <= (n_q >= sat_lim);
			q_q <= '0;
		end
		if (cmd.div) begin
			if (n_q >= dv_q) begin
				n_q <= n_q - dv_q;
				q_q <= {q_q[14:0], 1'b1};
			end else begin
				q_q <= {q_q[14:0], 1'b0};
			end
			dv_q <= dv_q >> 1;
		end
		if (cmd.out_load) begin
			out_data <= {1'b0, rp_q, recov_q, lost_q, move_q, turn_q, stopreq_q, en_q,
				steer_q, mode_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= 16'd2560;
			kd_q <= 16'd256;
			alpha_q <= 16'd16384;
			limit_q <= 15'd1600;
			hold_q <= 16'd100;
			stopms_q <= 16'd500;
			route_q <= '0;
			rlen_q <= '0;
			mode_q <= MODE_IDLE;
			filt_q <= '0;
			prev_q <= '0;
			latest_q <= '0;
			steer_q <= '0;
			ready_q <= 1'b0;
			ever_q <= 1'b0;
			lost_q <= 1'b0;
			recov_q <= 1'b0;
			held_q <= 1'b0;
			last_seen_q <= '0;
			lockout_q <= '0;
			last_cross_q <= '0;
			rp_q <= '0;
			en_q <= 1'b0;
			stopreq_q <= 1'b0;
			move_q <= 1'b0;
			turn_q <= TURN_NONE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PROP_GAIN: kp_q <= cfg_data[15:0];
					CFG_DERIV_GAIN: kd_q <= cfg_data[15:0];
					CFG_ALPHA: alpha_q <= cfg_data[15:0];
					CFG_STEER_LIMIT: limit_q <= cfg_data[14:0];
					CFG_HOLD_MS: hold_q <= cfg_data[15:0];
					CFG_STOP_MS: stopms_q <= cfg_data[15:0];
					CFG_ROUTE_CMDS: route_q <= cfg_data;
					CFG_ROUTE_LEN: begin
						rlen_q <= (len_in > 6'(ROUTE_MAX)) ? 5'(ROUTE_MAX) : cfg_data[4:0];
						rp_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				en_q <= 1'b0;
				stopreq_q <= 1'b0;
				move_q <= 1'b0;
				turn_q <= TURN_NONE;
			end
			if (cmd.eval) begin
				if (op_q == OP_RESET) begin
					mode_q <= MODE_IDLE;
					held_q <= 1'b0;
					last_cross_q <= '0;
					stopreq_q <= 1'b1;
				end else if (do_begin) begin
					mode_q <= MODE_FOLLOW;
					move_q <= 1'b1;
				end else if (follow_tick) begin
					if (on_q) begin
						latest_q <= err;
						last_seen_q <= now_q;
						ever_q <= 1'b1;
						lost_q <= 1'b0;
					end else begin
						lost_q <= 1'b1;
					end
					if (halt) begin
						mode_q <= MODE_STOP;
						stopreq_q <= 1'b1;
					end else if (recov) begin
						steer_q <= (prev_q >= 0) ? $signed(rec_mag) : -$signed(rec_mag);
						recov_q <= 1'b1;
						en_q <= 1'b1;
					end else begin
						recov_q <= 1'b0;
					end
				end
				if (do_clear) begin
					filt_q <= '0;
					prev_q <= '0;
					latest_q <= '0;
					steer_q <= '0;
					ready_q <= 1'b0;
					ever_q <= 1'b0;
					lost_q <= 1'b0;
					recov_q <= 1'b0;
					last_seen_q <= '0;
					lockout_q <= '0;
				end
				if (do_begin && op_q != OP_RESET) begin
					last_seen_q <= now_q;
					ever_q <= 1'b1;
				end
			end
			if (cmd.fadd) begin
				if (!ready_q) begin
					filt_q <= latest_q;
					prev_q <= latest_q;
					ready_q <= 1'b1;
				end else if (on_q) begin
					filt_q <= 16'(18'(filt_q) + fcorr);
				end
			end
			if (cmd.fin) begin
				steer_q <= s_val;
				prev_q <= filt_q;
				en_q <= 1'b1;
				if (now_q >= lockout_q) begin
					if (hit) begin
						held_q <= 1'b1;
						last_cross_q <= now_q;
						lockout_q <= now_q + 32'(LOCKOUT_MS);
						if (rp_q < rlen_q) begin
							rp_q <= rp_q + 1'b1;
							if (entry == ROUTE_LEFT) begin
								mode_q <= MODE_LEFT;
								turn_q <= TURN_POS90;
								en_q <= 1'b0;
							end else if (entry == ROUTE_RIGHT) begin
								mode_q <= MODE_RIGHT;
								turn_q <= TURN_NEG90;
								en_q <= 1'b0;
							end
						end
					end else if (!cross_q) begin
						held_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/line_follow_pd_steering_top.sv -----
// Top level of the line-follow PD steering controller.
// Depends on lfpd_pkg, lfpd_ctrl and lfpd_dp.
//
// Each beat on the s_ channel is one item: a control tick, a start command or a
// reset command (selected by s_tuser). Every item produces exactly one result beat
// on the m_ channel. Configuration registers are written through the cfg_ channel,
// which is always ready; write them only while no item is in flight.
// Ticks that run the PD path go from acceptance to the result beat through
// evaluation, the error filter multiply and add, two registered multiply stages,
// a sum and a saturation check, then a 16-step restoring divider that produces
// one quotient bit per cycle. All other items go from evaluation to the result.
// One item is processed at a time; s_tready is high only while the block is idle.
// The result sits in an output register, so the block takes the next item while a
// result waits; a stalled receiver then holds that next item in its final state
// until m_tready is seen, after which it accepts again.
// Reset clears the follower to idle with the documented register defaults.
`timescale 1ns / 1ps
`default_nettype none
module line_follow_pd_steering_top
	import lfpd_pkg::*;
#(
	parameter int ROUTE_MAX   = 16,
	parameter int DEBOUNCE_MS = 200,
	parameter int LOCKOUT_MS  = 500
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// now_ms[31:0], dt_us[47:32], on_line[48], line_position[64:49],
	// intersection_seen[65], turn_done[66], zero fill above.
	input  wire logic [71:0]          s_tdata,
	// op[1:0].
	input  wire logic [OP_W-1:0]      s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// mode[2:0], steering[18:3], steering_enabled[19], stop_request[20],
	// turn_request[22:21], move_start[23], line_lost[24], recovery_active[25],
	// route_position[30:26], zero fill above.
	output logic [31:0]               m_tdata,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	lfpd_cmd_t cmd;
	lfpd_sts_t sts;

	assign cfg_ready = 1'b1;

	lfpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lfpd_dp #(
		.ROUTE_MAX   (ROUTE_MAX),
		.DEBOUNCE_MS (DEBOUNCE_MS),
		.LOCKOUT_MS  (LOCKOUT_MS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.in_op     (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire
